// ===== rtl/mste_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the multi-stack transfer engine.
// Holds the microcode store of the sequencer; depends on nothing else.
package mste_pkg;

    // Item kinds carried on the kind field.
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_MOVE   = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    // A report never covers more stacks than this.
    localparam int REPORT_MAX = 16;

    typedef enum logic [3:0] {
        STP_IDLE     = 4'd0,
        STP_PSH_RD   = 4'd1,
        STP_PSH_WR   = 4'd2,
        STP_MV_RDS   = 4'd3,
        STP_MV_RDT   = 4'd4,
        STP_MV_CAPT  = 4'd5,
        STP_MV_LOOP  = 4'd6,
        STP_MV_XFER  = 4'd7,
        STP_MV_WBS   = 4'd8,
        STP_MV_WBT   = 4'd9,
        STP_RP_RD    = 4'd10,
        STP_RP_FETCH = 4'd11,
        STP_RP_OUT   = 4'd12
    } t_step;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_DISPATCH,
        ACT_PUSH,
        ACT_CAP_SRC,
        ACT_CAP_TGT,
        ACT_MV_RD,
        ACT_MV_WR,
        ACT_REP_FETCH,
        ACT_REP_OUT
    } t_act;

    typedef enum logic [1:0] {
        HSEL_TGT,
        HSEL_SRC,
        HSEL_IDX
    } t_hsel;

    typedef enum logic [1:0] {
        HWR_NONE,
        HWR_PUSH,
        HWR_SRC,
        HWR_TGT
    } t_hwr;

    typedef enum logic [1:0] {
        JMP_ALWAYS,
        JMP_DISPATCH,
        JMP_MV_STOP,
        JMP_REP_LAST
    } t_jmp;

    typedef struct packed {
        t_act  act;
        t_hsel hsel;
        t_hwr  hwr;
        t_jmp  jc;
        t_step jt;
        t_step jf;
    } t_uword;

    // Control store: one word per step; jt is taken when the condition holds.
    function automatic t_uword ucode(t_step pc);
        t_uword w;
        case (pc)
            STP_IDLE:     w = '{ACT_DISPATCH,  HSEL_TGT, HWR_NONE, JMP_DISPATCH,
                                 STP_IDLE, STP_IDLE};
            STP_PSH_RD:   w = '{ACT_NONE,      HSEL_TGT, HWR_NONE, JMP_ALWAYS,
                                 STP_PSH_WR, STP_PSH_WR};
            STP_PSH_WR:   w = '{ACT_PUSH,      HSEL_TGT, HWR_PUSH, JMP_ALWAYS,
                                 STP_IDLE, STP_IDLE};
            STP_MV_RDS:   w = '{ACT_NONE,      HSEL_SRC, HWR_NONE, JMP_ALWAYS,
                                 STP_MV_RDT, STP_MV_RDT};
            STP_MV_RDT:   w = '{ACT_CAP_SRC,   HSEL_TGT, HWR_NONE, JMP_ALWAYS,
                                 STP_MV_CAPT, STP_MV_CAPT};
            STP_MV_CAPT:  w = '{ACT_CAP_TGT,   HSEL_TGT, HWR_NONE, JMP_ALWAYS,
                                 STP_MV_LOOP, STP_MV_LOOP};
            STP_MV_LOOP:  w = '{ACT_MV_RD,     HSEL_TGT, HWR_NONE, JMP_MV_STOP,
                                 STP_MV_WBS, STP_MV_XFER};
            STP_MV_XFER:  w = '{ACT_MV_WR,     HSEL_TGT, HWR_NONE, JMP_ALWAYS,
                                 STP_MV_LOOP, STP_MV_LOOP};
            STP_MV_WBS:   w = '{ACT_NONE,      HSEL_TGT, HWR_SRC,  JMP_ALWAYS,
                                 STP_MV_WBT, STP_MV_WBT};
            STP_MV_WBT:   w = '{ACT_NONE,      HSEL_TGT, HWR_TGT,  JMP_ALWAYS,
                                 STP_IDLE, STP_IDLE};
            STP_RP_RD:    w = '{ACT_NONE,      HSEL_IDX, HWR_NONE, JMP_ALWAYS,
                                 STP_RP_FETCH, STP_RP_FETCH};
            STP_RP_FETCH: w = '{ACT_REP_FETCH, HSEL_IDX, HWR_NONE, JMP_ALWAYS,
                                 STP_RP_OUT, STP_RP_OUT};
            STP_RP_OUT:   w = '{ACT_REP_OUT,   HSEL_IDX, HWR_NONE, JMP_REP_LAST,
                                 STP_IDLE, STP_RP_RD};
            default:      w = '{ACT_NONE,      HSEL_TGT, HWR_NONE, JMP_ALWAYS,
                                 STP_IDLE, STP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/multi_stack_transfer_engine_core.sv =====
`timescale 1ns / 1ps
// Multi-stack transfer engine: push, move and report on a bank of byte stacks.
// A push keeps busy high while it reads the target height and writes the byte; a move
// while it reads both heights, makes its transfers (one stack RAM read then one write
// each) and writes both heights back; a report gives one result per stack in turn.
// Results cannot be held off. Synchronous active-low reset empties every stack,
// clears the overflow flag and returns the sequencer to idle.
module multi_stack_transfer_engine_core #(
    parameter int NUM_STACKS  = 16,
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  logic [3:0] i_target_stack,
    input  logic [3:0] i_source_stack,
    input  logic [6:0] i_amount,
    input  logic [7:0] i_crate,
    output logic       o_strobe,
    output logic [3:0] o_stack_number,
    output logic [7:0] o_top_value,
    output logic       o_is_empty,
    output logic       o_overflowed,
    output logic       o_last
);

    // Widths: stack index, stack height (which can equal the depth) and store address.
    localparam int SW   = $clog2(NUM_STACKS);
    localparam int HW   = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(NUM_STACKS * STACK_DEPTH);
    localparam int RCNT = (NUM_STACKS < mste_pkg::REPORT_MAX) ? NUM_STACKS
                                                               : mste_pkg::REPORT_MAX;
    localparam logic [SW-1:0] LAST_IDX = SW'(RCNT - 1);
    localparam logic [HW-1:0] FULL_H   = HW'(STACK_DEPTH);

    // The store is laid out stack after stack, each stack STACK_DEPTH bytes long.
    function automatic logic [AW-1:0] slot(logic [SW-1:0] stk, logic [HW-1:0] pos);
        return AW'(stk) * AW'(STACK_DEPTH) + AW'(pos);
    endfunction

    // Sequencer state and latched item fields.
    mste_pkg::t_step  r_pc;
    mste_pkg::t_step  n_pc;
    mste_pkg::t_uword uw;
    logic [SW-1:0]    r_tgt;
    logic [SW-1:0]    r_src;
    logic [SW-1:0]    r_k;
    logic [6:0]       r_cnt;
    logic [7:0]       r_crate;
    logic [HW-1:0]    r_sh;
    logic [HW-1:0]    r_th;
    logic             r_empty;
    logic             r_ovf;

    // Height store: a RAM plus one valid bit per stack, so that reset empties
    // every stack at once. A stack never written reads as height zero.
    logic [NUM_STACKS-1:0] r_valid;
    logic                  r_hv;
    logic [SW-1:0]         h_raddr;
    logic [HW-1:0]         h_q;
    logic [HW-1:0]         h_rd;
    logic                  h_we;
    logic [SW-1:0]         h_waddr;
    logic [HW-1:0]         h_wdata;

    // Byte store.
    logic          s_we;
    logic [AW-1:0] s_waddr;
    logic [7:0]    s_wdata;
    logic [AW-1:0] s_raddr;
    logic [7:0]    s_q;

    logic accept;
    logic tgt_ok;
    logic src_ok;
    logic push_full;
    logic mv_stop;
    logic ovf_set;

    assign uw     = mste_pkg::ucode(r_pc);
    assign busy   = (r_pc != mste_pkg::STP_IDLE);
    assign accept = start && !busy;
    assign tgt_ok = ({28'd0, i_target_stack} < 32'(NUM_STACKS));
    assign src_ok = ({28'd0, i_source_stack} < 32'(NUM_STACKS));

    // Height read data is only meaningful in the step after its address was set.
    assign h_rd      = r_hv ? h_q : '0;
    assign push_full = (h_rd >= FULL_H);
    // A move ends when its amount is spent, the source is empty or the target full.
    assign mv_stop   = (r_cnt == 7'd0) || (r_sh == '0) || (r_th >= FULL_H);
    // The empty-source test comes first, so an empty source never sets the flag.
    assign ovf_set   = ((uw.act == mste_pkg::ACT_PUSH) && push_full) ||
                       ((uw.act == mste_pkg::ACT_MV_RD) && (r_cnt != 7'd0) &&
                        (r_sh != '0) && (r_th >= FULL_H));

    // Datapath controls decoded from the current control word.
    always_comb begin
        case (uw.hsel)
            mste_pkg::HSEL_SRC: h_raddr = r_src;
            mste_pkg::HSEL_IDX: h_raddr = r_k;
            default:            h_raddr = r_tgt;
        endcase

        h_we    = 1'b0;
        h_waddr = r_tgt;
        h_wdata = r_th;
        case (uw.hwr)
            mste_pkg::HWR_PUSH: begin
                h_we    = !push_full;
                h_wdata = h_rd + HW'(1);
            end
            mste_pkg::HWR_SRC: begin
                h_we    = 1'b1;
                h_waddr = r_src;
                h_wdata = r_sh;
            end
            mste_pkg::HWR_TGT: begin
                h_we    = 1'b1;
            end
            default: begin
                h_we    = 1'b0;
            end
        endcase

        // Report reads the top of stack r_k; otherwise the top of the source.
        if (uw.act == mste_pkg::ACT_REP_FETCH) begin
            s_raddr = slot(r_k, h_rd - HW'(1));
        end else begin
            s_raddr = slot(r_src, r_sh - HW'(1));
        end

        s_we    = 1'b0;
        s_waddr = slot(r_tgt, r_th);
        s_wdata = s_q;
        case (uw.act)
            mste_pkg::ACT_PUSH: begin
                s_we    = !push_full;
                s_waddr = slot(r_tgt, h_rd);
                s_wdata = r_crate;
            end
            mste_pkg::ACT_MV_WR: begin
                s_we    = 1'b1;
            end
            default: begin
                s_we    = 1'b0;
            end
        endcase
    end

    // Next step: every control word but the idle one names its own targets; idle dispatches on the kind.
    always_comb begin
        case (uw.jc)
            mste_pkg::JMP_DISPATCH: begin
                n_pc = mste_pkg::STP_IDLE;
                if (start) begin
                    case (i_kind)
                        mste_pkg::KIND_PUSH: begin
                            if (tgt_ok) begin
                                n_pc = mste_pkg::STP_PSH_RD;
                            end
                        end
                        mste_pkg::KIND_MOVE: begin
                            // A move onto its own source changes nothing.
                            if (tgt_ok && src_ok && (i_target_stack != i_source_stack)) begin
                                n_pc = mste_pkg::STP_MV_RDS;
                            end
                        end
                        mste_pkg::KIND_REPORT: begin
                            n_pc = mste_pkg::STP_RP_RD;
                        end
                        default: begin
                            n_pc = mste_pkg::STP_IDLE;
                        end
                    endcase
                end
            end
            mste_pkg::JMP_MV_STOP:  n_pc = mv_stop ? uw.jt : uw.jf;
            mste_pkg::JMP_REP_LAST: n_pc = (r_k == LAST_IDX) ? uw.jt : uw.jf;
            default:                n_pc = uw.jt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= mste_pkg::STP_IDLE;
            r_valid  <= '0;
            r_ovf    <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            o_strobe <= (uw.act == mste_pkg::ACT_REP_OUT);
            if (h_we) begin
                r_valid[h_waddr] <= 1'b1;
            end
            if (ovf_set) begin
                r_ovf <= 1'b1;
            end

            r_hv <= r_valid[h_raddr];
            case (uw.act)
                mste_pkg::ACT_DISPATCH: begin
                    if (accept) begin
                        r_tgt   <= SW'(i_target_stack);
                        r_src   <= SW'(i_source_stack);
                        r_cnt   <= i_amount;
                        r_crate <= i_crate;
                        r_k     <= '0;
                    end
                end
                mste_pkg::ACT_CAP_SRC: begin
                    r_sh <= h_rd;
                end
                mste_pkg::ACT_CAP_TGT: begin
                    r_th <= h_rd;
                end
                mste_pkg::ACT_MV_RD: begin
                    // The read of the source top is issued this cycle.
                    if (!mv_stop) begin
                        r_sh  <= r_sh - HW'(1);
                        r_cnt <= r_cnt - 7'd1;
                    end
                end
                mste_pkg::ACT_MV_WR: begin
                    r_th <= r_th + HW'(1);
                end
                mste_pkg::ACT_REP_FETCH: begin
                    r_empty <= (h_rd == '0);
                end
                mste_pkg::ACT_REP_OUT: begin
                    o_stack_number <= 4'(r_k);
                    o_top_value    <= r_empty ? 8'd0 : s_q;
                    o_is_empty     <= r_empty;
                    o_overflowed   <= r_ovf;
                    o_last         <= (r_k == LAST_IDX);
                    r_k            <= r_k + SW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    mste_ram #(
        .WIDTH (HW),
        .DEPTH (NUM_STACKS)
    ) u_heights (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_q)
    );

    mste_ram #(
        .WIDTH (8),
        .DEPTH (NUM_STACKS * STACK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_q)
    );

endmodule

// ===== rtl/mste_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Stands alone; used for stack contents and stack heights.
module mste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/mste_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the multi-stack transfer engine, bound to its top level.
// Depends on mste_pkg for the item kind codes.
module mste_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_kind,
    input logic       o_strobe,
    input logic [7:0] o_top_value,
    input logic       o_is_empty,
    input logic       o_last
);

    // An accepted report always occupies the engine.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == mste_pkg::KIND_REPORT)) |=> busy)
        else $error("report accepted but engine not busy");

    // A report result that is not the last one means more results are pending.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("report ended before its last result");

    // Results of one report are spaced out; never two in consecutive cycles.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results in consecutive cycles");

    // An empty stack reports a zero top byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_empty) |-> (o_top_value == 8'd0))
        else $error("empty stack reported a non-zero top");

endmodule

bind multi_stack_transfer_engine_core mste_checker u_mste_checker (.*);

// ===== bench/multi_stack_transfer_engine_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the multi-stack transfer engine core: push, move and report
// items against a cycle-free predictor of the stack bank. Depends on mste_pkg and the core.
module multi_stack_transfer_engine_core_test;

    // The core is built with its default sizes, so the bench mirrors them here.
    localparam int STACKS     = 16;
    localparam int DEPTH      = 64;
    localparam int REPORT_LEN = (STACKS < mste_pkg::REPORT_MAX) ? STACKS
                                                                : mste_pkg::REPORT_MAX;

    // The fourth kind code has no meaning and must be ignored by the core.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 125;
    // The tail covers the longest move, that of a full stack, and the watchdog allows
    // that plus the longest gap.
    localparam int TAIL_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 1500;
    localparam int MAX_REPORTED   = 100;

    typedef struct packed {
        logic [3:0] stack_number;
        logic [7:0] top_value;
        logic       is_empty;
        logic       overflowed;
        logic       last;
    } t_top_report;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       start          = 1'b0;
    logic [1:0] i_kind         = '0;
    logic [3:0] i_target_stack = '0;
    logic [3:0] i_source_stack = '0;
    logic [6:0] i_amount       = '0;
    logic [7:0] i_crate        = '0;
    logic       busy;
    logic       o_strobe;
    logic [3:0] o_stack_number;
    logic [7:0] o_top_value;
    logic       o_is_empty;
    logic       o_overflowed;
    logic       o_last;

    // Predicted contents of the stack bank. Only entries below a stack's fill level are
    // ever read, so the untouched part of the store never matters.
    logic [7:0]  mem_bytes [STACKS][DEPTH];
    int          fill_level [STACKS];
    logic        ovf_seen = 1'b0;
    t_top_report top_reports_q[$];

    int mismatches   = 0;
    int stall_cycles = 0;
    int no_gap_left  = 0;

    multi_stack_transfer_engine_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_target_stack (i_target_stack),
        .i_source_stack (i_source_stack),
        .i_amount       (i_amount),
        .i_crate        (i_crate),
        .o_strobe       (o_strobe),
        .o_stack_number (o_stack_number),
        .o_top_value    (o_top_value),
        .o_is_empty     (o_is_empty),
        .o_overflowed   (o_overflowed),
        .o_last         (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Updates the predicted stacks for one accepted item and, for a report, queues
    // the top of every stack in index order. With sixteen stacks every 4-bit index
    // names a real stack, so no item is dropped for an out-of-range index.
    task automatic predict_stack_tops(input logic [1:0] kind, input logic [3:0] tgt,
                                      input logic [3:0] src, input logic [6:0] amt,
                                      input logic [7:0] crate);
        int          n;
        t_top_report entry;
        case (kind)
            mste_pkg::KIND_PUSH: begin
                if (fill_level[tgt] >= DEPTH) begin
                    ovf_seen = 1'b1;
                end else begin
                    mem_bytes[tgt][fill_level[tgt]] = crate;
                    fill_level[tgt]++;
                end
            end
            mste_pkg::KIND_MOVE: begin
                // A move onto itself does nothing. Otherwise an empty source ends the
                // move before the target is looked at, so it never raises the flag.
                if (tgt != src) begin
                    for (n = 0; n < amt; n++) begin
                        if (fill_level[src] == 0)
                            break;
                        if (fill_level[tgt] >= DEPTH) begin
                            ovf_seen = 1'b1;
                            break;
                        end
                        fill_level[src]--;
                        mem_bytes[tgt][fill_level[tgt]] = mem_bytes[src][fill_level[src]];
                        fill_level[tgt]++;
                    end
                end
            end
            mste_pkg::KIND_REPORT: begin
                for (n = 0; n < REPORT_LEN; n++) begin
                    entry.stack_number = n[3:0];
                    entry.is_empty     = (fill_level[n] == 0);
                    if (entry.is_empty)
                        entry.top_value = 8'h00;
                    else
                        entry.top_value = mem_bytes[n][fill_level[n] - 1];
                    entry.overflowed   = ovf_seen;
                    entry.last         = (n == REPORT_LEN - 1);
                    top_reports_q      = {top_reports_q, entry};
                end
            end
            default: begin
            end
        endcase
    endtask

    // Presents one item after a random gap and returns at the edge that accepts it.
    // It is entered and left on a rising edge; when no gap follows, start simply stays
    // high for the next item rather than dropping for a cycle.
    task automatic send_item(input logic [1:0] kind, input logic [3:0] tgt,
                             input logic [3:0] src, input logic [6:0] amt,
                             input logic [7:0] crate);
        int gap;
        int pick;
        if (no_gap_left > 0) begin
            no_gap_left--;
            gap = 0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                // Now and then a run of back-to-back transfers.
                no_gap_left = $urandom_range(8, 24);
                gap = 0;
            end else if (pick < 45) begin
                gap = 0;
            end else if (pick < 85) begin
                gap = $urandom_range(1, 3);
            end else if (pick < 97) begin
                gap = $urandom_range(4, 12);
            end else begin
                gap = $urandom_range(20, 40);
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_target_stack <= tgt;
        i_source_stack <= src;
        i_amount       <= amt;
        i_crate        <= crate;
        // busy is read before the edge updates it, so a low value here means the
        // item is taken at this very edge.
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_stack_tops(kind, tgt, src, amt, crate);
    endtask

    task automatic compare_field(input string field_name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            // Beyond a hundred lines a broken core only floods the log.
            if (mismatches <= MAX_REPORTED)
                $display("%0t: %s expected %0h, actual %0h", $time, field_name, want, got);
        end
    endtask

    // Every strobe is one report transfer and must match the oldest predicted top.
    always @(posedge i_clk) begin : check_results
        t_top_report want;
        if (i_rst_n && o_strobe) begin
            if (top_reports_q.size() == 0) begin
                mismatches++;
                $display("%0t: result for stack %0d with none expected, expected nothing, actual %0h",
                         $time, o_stack_number, o_top_value);
            end else begin
                want = top_reports_q.pop_front();
                compare_field("stack_number", 8'(want.stack_number), 8'(o_stack_number));
                compare_field("top_value", want.top_value, o_top_value);
                compare_field("is_empty", 8'(want.is_empty), 8'(o_is_empty));
                compare_field("overflowed", 8'(want.overflowed), 8'(o_overflowed));
                compare_field("last", 8'(want.last), 8'(o_last));
            end
        end
    end

    // Ends a hung run: a cycle with an accepted item or a result restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Extreme byte values on the first and last stacks, with the unused fields of some
    // pushes held at all ones, and a report of an empty bank first of all.
    task automatic test_directed_pushes();
        send_item(mste_pkg::KIND_REPORT, 4'h0, 4'h0, 7'd0, 8'h00);
        send_item(mste_pkg::KIND_PUSH, 4'd0, 4'hF, 7'h7F, 8'h00);
        send_item(mste_pkg::KIND_PUSH, 4'd15, 4'hF, 7'h7F, 8'hFF);
        send_item(mste_pkg::KIND_PUSH, 4'd15, 4'h0, 7'd0, 8'hA5);
        send_item(mste_pkg::KIND_PUSH, 4'd0, 4'h5, 7'h2A, 8'h5A);
        send_item(mste_pkg::KIND_REPORT, 4'hF, 4'hF, 7'h7F, 8'hFF);
    endtask

    // Zero amount, a stack moved onto itself, an empty source, a single transfer,
    // an amount far beyond the stack depth, and an item of the unused kind.
    task automatic test_directed_moves();
        send_item(mste_pkg::KIND_MOVE, 4'd0, 4'd15, 7'd0, 8'h00);
        send_item(mste_pkg::KIND_MOVE, 4'd15, 4'd15, 7'd5, 8'h00);
        send_item(mste_pkg::KIND_MOVE, 4'd0, 4'd3, 7'd4, 8'h00);
        send_item(mste_pkg::KIND_MOVE, 4'd7, 4'd15, 7'd1, 8'h00);
        send_item(mste_pkg::KIND_MOVE, 4'd7, 4'd0, 7'd127, 8'hFF);
        send_item(KIND_UNUSED, 4'hF, 4'hF, 7'h7F, 8'hFF);
        send_item(mste_pkg::KIND_REPORT, 4'd0, 4'd0, 7'd0, 8'h00);
        send_item(mste_pkg::KIND_MOVE, 4'd15, 4'd7, 7'd64, 8'h00);
        send_item(mste_pkg::KIND_REPORT, 4'd0, 4'd0, 7'd0, 8'h00);
    endtask

    // Fills one stack to the brim, then works the cases around a full stack: an empty
    // source moving onto it, a move that stops part-way, and a dropped push.
    task automatic test_full_stack();
        int full_stk;
        int spare_stk;
        int drain_stk;
        full_stk  = $urandom_range(0, STACKS - 1);
        spare_stk = (full_stk + 1 + $urandom_range(0, STACKS - 2)) % STACKS;
        do
            drain_stk = $urandom_range(0, STACKS - 1);
        while (drain_stk == full_stk || drain_stk == spare_stk);

        // Empty the drain stack so that it can serve as an empty source later on.
        if (fill_level[drain_stk] != 0)
            send_item(mste_pkg::KIND_MOVE, 4'(spare_stk), 4'(drain_stk), 7'd127,
                      8'($urandom_range(0, 255)));
        while (fill_level[full_stk] < DEPTH)
            send_item(mste_pkg::KIND_PUSH, 4'(full_stk), 4'($urandom_range(0, 15)),
                      7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
        send_item(mste_pkg::KIND_MOVE, 4'(full_stk), 4'(drain_stk),
                  7'($urandom_range(1, 127)), 8'h00);
        send_item(mste_pkg::KIND_REPORT, 4'd0, 4'd0, 7'd0, 8'h00);

        // Make room for exactly three, then ask for ten: three go across and the
        // rest stay behind in the source.
        send_item(mste_pkg::KIND_MOVE, 4'(spare_stk), 4'(full_stk), 7'd3, 8'h00);
        while (fill_level[spare_stk] < 8)
            send_item(mste_pkg::KIND_PUSH, 4'(spare_stk), 4'd0, 7'd0,
                      8'($urandom_range(0, 255)));
        send_item(mste_pkg::KIND_MOVE, 4'(full_stk), 4'(spare_stk), 7'd10, 8'h00);
        send_item(mste_pkg::KIND_REPORT, 4'd0, 4'd0, 7'd0, 8'h00);
        send_item(mste_pkg::KIND_PUSH, 4'(full_stk), 4'd0, 7'd0, 8'($urandom_range(0, 255)));
        send_item(mste_pkg::KIND_REPORT, 4'd0, 4'd0, 7'd0, 8'h00);
    endtask

    // Mostly pushes and moves of a few bytes, with reports scattered among them, and
    // some noise: same-stack moves, long amounts and items of the unused kind.
    task automatic test_random_traffic();
        int         counted;
        int         pick;
        int         span;
        logic [3:0] stk_a;
        logic [3:0] stk_b;
        logic [6:0] amt;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick  = $urandom_range(0, 99);
            stk_a = 4'($urandom_range(0, 15));
            stk_b = 4'($urandom_range(0, 15));
            span  = $urandom_range(0, 9);
            if (span < 7)
                amt = 7'($urandom_range(0, 6));
            else if (span < 9)
                amt = 7'($urandom_range(7, 64));
            else
                amt = 7'($urandom_range(65, 127));
            if (pick < 5) begin
                // Ignored by the core, so it does not count towards the total.
                send_item(KIND_UNUSED, stk_a, stk_b, amt, 8'($urandom_range(0, 255)));
            end else begin
                counted++;
                if (pick < 45)
                    send_item(mste_pkg::KIND_PUSH, stk_a, stk_b, amt,
                              8'($urandom_range(0, 255)));
                else if (pick < 80)
                    send_item(mste_pkg::KIND_MOVE, stk_a, stk_b, amt,
                              8'($urandom_range(0, 255)));
                else if (pick < 85)
                    send_item(mste_pkg::KIND_MOVE, stk_a, stk_a, amt,
                              8'($urandom_range(0, 255)));
                else
                    send_item(mste_pkg::KIND_REPORT, stk_a, stk_b, amt,
                              8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        foreach (fill_level[n])
            fill_level[n] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed_pushes();
        test_directed_moves();
        test_full_stack();
        test_random_traffic();
        start <= 1'b0;

        // Drain every predicted result, then watch a while longer for stray strobes.
        while (top_reports_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mste_pkg.sv
rtl/mste_ram.sv
rtl/multi_stack_transfer_engine_core.sv
rtl/mste_checker.sv
bench/multi_stack_transfer_engine_core_test.sv
